// ===== hdl/fcde_pkg.sv =====
// Shared constants, command codes and control/status types for the draw engine.
// Used by every file of the block except fcde_ram; depends on nothing.
package fcde_pkg;

  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 240;
  localparam int STORE_DEPTH = SCREEN_W * SCREEN_H;

  localparam int OP_W   = 3;
  localparam int CRD_W  = 13;
  localparam int COL_W  = 16;
  localparam int EXT_W  = CRD_W + 2;
  localparam int XW     = $clog2(SCREEN_W + 1);
  localparam int YW     = $clog2(SCREEN_H + 1);
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  localparam int OUTLINE_PASSES = 4;
  localparam int PASS_W = $clog2(OUTLINE_PASSES);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_PLOT    = 3'd1,
    OP_FILL    = 3'd2,
    OP_OUTLINE = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef struct packed {
    logic load;
    logic clip;
    logic base;
    logic step;
    logic next_pass;
    logic ram_we;
    logic ram_re;
    logic result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic is_read;
    logic last_pass;
    logic col_last;
    logic row_last;
  } dp_stat_t;

endpackage

// ===== hdl/fcde_in_if.sv =====
// Command channel: valid/ready handshake with one drawing command per beat.
// Depends on fcde_pkg for field widths.
interface fcde_in_if;
  logic                             valid;
  logic                             ready;
  logic [fcde_pkg::OP_W-1:0]        op;
  logic signed [fcde_pkg::CRD_W-1:0] pos_x;
  logic signed [fcde_pkg::CRD_W-1:0] pos_y;
  logic signed [fcde_pkg::CRD_W-1:0] span_w;
  logic signed [fcde_pkg::CRD_W-1:0] span_h;
  logic [fcde_pkg::COL_W-1:0]       colour;

  modport source (output valid, op, pos_x, pos_y, span_w, span_h, colour, input ready);
  modport sink   (input valid, op, pos_x, pos_y, span_w, span_h, colour, output ready);
endinterface

// ===== hdl/fcde_out_if.sv =====
// Result channel: valid/ready handshake with one result per beat.
// Depends on fcde_pkg for field widths.
interface fcde_out_if;
  logic                       valid;
  logic                       ready;
  logic [fcde_pkg::COL_W-1:0] pixel_value;
  logic                       read_in_bounds;

  modport source (output valid, pixel_value, read_in_bounds, input ready);
  modport sink   (input valid, pixel_value, read_in_bounds, output ready);
endinterface

// ===== hdl/fcde_ram.sv =====
// Generic single-port RAM with registered read data.
// Standalone; no package dependency.
module fcde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/fcde_ctrl.sv =====
// Command sequencer: walks each command through clip, row setup, pixel sweep
// and result hand-off. Depends on fcde_pkg for the control and status structs.
module fcde_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  fcde_pkg::dp_stat_t   stat,
  output fcde_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CLIP   = 5'b00010,
    S_BASE   = 5'b00100,
    S_RUN    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CLIP;
        end
      end
      S_CLIP: begin
        cmd.clip  = 1'b1;
        state_nxt = S_BASE;
      end
      S_BASE: begin
        cmd.base = 1'b1;
        if (stat.empty) begin
          if (stat.last_pass) begin
            state_nxt = S_FINISH;
          end else begin
            cmd.next_pass = 1'b1;
            state_nxt     = S_CLIP;
          end
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (stat.is_read) begin
          cmd.ram_re = 1'b1;
          state_nxt  = S_FINISH;
        end else begin
          cmd.ram_we = 1'b1;
          cmd.step   = 1'b1;
          if (stat.col_last && stat.row_last) begin
            if (stat.last_pass) begin
              state_nxt = S_FINISH;
            end else begin
              cmd.next_pass = 1'b1;
              state_nxt     = S_CLIP;
            end
          end
        end
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.result    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== hdl/fcde_dp.sv =====
// Datapath: command registers, rectangle clipping, pixel sweep counters,
// frame store and result register. Depends on fcde_pkg and fcde_ram.
module fcde_dp (
  input  logic                              clk,
  input  fcde_pkg::ctrl_cmd_t               cmd,
  output fcde_pkg::dp_stat_t                stat,
  input  logic [fcde_pkg::OP_W-1:0]         in_op,
  input  logic signed [fcde_pkg::CRD_W-1:0] in_pos_x,
  input  logic signed [fcde_pkg::CRD_W-1:0] in_pos_y,
  input  logic signed [fcde_pkg::CRD_W-1:0] in_span_w,
  input  logic signed [fcde_pkg::CRD_W-1:0] in_span_h,
  input  logic [fcde_pkg::COL_W-1:0]        in_colour,
  output logic [fcde_pkg::COL_W-1:0]        out_pixel_value,
  output logic                              out_read_in_bounds
);

  localparam int EW = fcde_pkg::EXT_W;
  localparam int XW = fcde_pkg::XW;
  localparam int YW = fcde_pkg::YW;
  localparam int AW = fcde_pkg::ADDR_W;
  localparam int PW = fcde_pkg::PASS_W;
  localparam logic signed [EW-1:0] SW_S = EW'(fcde_pkg::SCREEN_W);
  localparam logic signed [EW-1:0] SH_S = EW'(fcde_pkg::SCREEN_H);
  localparam logic signed [EW-1:0] ONE_S = EW'(1);
  localparam logic signed [EW-1:0] ZERO_S = '0;

  logic [fcde_pkg::OP_W-1:0]         op_r;
  logic signed [fcde_pkg::CRD_W-1:0] x_r, y_r, w_r, h_r;
  logic [fcde_pkg::COL_W-1:0]        colour_r;
  logic [PW-1:0]                     pass_r;
  logic [XW-1:0]                     x0_r, x1_r, cx_r;
  logic [YW-1:0]                     y0_r, y1_r, cy_r;
  logic                              empty_r;
  logic [AW-1:0]                     base_r;
  logic [fcde_pkg::COL_W-1:0]        pix_r;
  logic                              inb_r;

  logic signed [EW-1:0] ex, ey, ew, eh;
  logic signed [EW-1:0] xs, xe, ys, ye;
  logic signed [EW-1:0] cx0, cx1, cy0, cy1;
  logic                 bad_op, clip_empty, is_read;
  logic [XW-1:0]        cx_inc;
  logic [YW-1:0]        cy_inc;
  logic [AW-1:0]        ram_addr;
  logic [fcde_pkg::COL_W-1:0] ram_rdata;

  assign ex = EW'(x_r);
  assign ey = EW'(y_r);
  assign ew = EW'(w_r);
  assign eh = EW'(h_r);

  always_comb begin
    bad_op = 1'b0;
    xs = ex;
    xe = ex + ONE_S;
    ys = ey;
    ye = ey + ONE_S;
    unique case (op_r) inside
      fcde_pkg::OP_CLEAR: begin
        xs = ZERO_S;
        xe = SW_S;
        ys = ZERO_S;
        ye = SH_S;
      end
      fcde_pkg::OP_PLOT, fcde_pkg::OP_READ: begin
        xs = ex;
        xe = ex + ONE_S;
        ys = ey;
        ye = ey + ONE_S;
      end
      fcde_pkg::OP_FILL: begin
        xs = ex;
        xe = ex + ew;
        ys = ey;
        ye = ey + eh;
      end
      fcde_pkg::OP_OUTLINE: begin
        case (pass_r)
          PW'(0): begin
            xs = ex;
            xe = ex + ew;
            ys = ey;
            ye = ey + ONE_S;
          end
          PW'(1): begin
            xs = ex;
            xe = ex + ew;
            ys = ey + eh - ONE_S;
            ye = ey + eh;
          end
          PW'(2): begin
            xs = ex;
            xe = ex + ONE_S;
            ys = ey;
            ye = ey + eh;
          end
          default: begin
            xs = ex + ew - ONE_S;
            xe = ex + ew;
            ys = ey;
            ye = ey + eh;
          end
        endcase
      end
      default: begin
        bad_op = 1'b1;
      end
    endcase
    cx0 = (xs < ZERO_S) ? ZERO_S : xs;
    cx1 = (xe > SW_S) ? SW_S : xe;
    cy0 = (ys < ZERO_S) ? ZERO_S : ys;
    cy1 = (ye > SH_S) ? SH_S : ye;
    clip_empty = bad_op || (cx1 <= cx0) || (cy1 <= cy0);
  end

  assign is_read = (op_r == fcde_pkg::OP_READ);
  assign cx_inc  = cx_r + XW'(1);
  assign cy_inc  = cy_r + YW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      x_r      <= in_pos_x;
      y_r      <= in_pos_y;
      w_r      <= in_span_w;
      h_r      <= in_span_h;
      colour_r <= in_colour;
      pass_r   <= '0;
    end else if (cmd.next_pass) begin
      pass_r <= pass_r + PW'(1);
    end
    if (cmd.clip) begin
      x0_r    <= XW'(cx0);
      x1_r    <= XW'(cx1);
      y0_r    <= YW'(cy0);
      y1_r    <= YW'(cy1);
      empty_r <= clip_empty;
    end
    if (cmd.base) begin
      base_r <= AW'(AW'(y0_r) * AW'(fcde_pkg::SCREEN_W));
      cx_r   <= x0_r;
      cy_r   <= y0_r;
    end else if (cmd.step) begin
      if (cx_inc == x1_r) begin
        cx_r   <= x0_r;
        cy_r   <= cy_inc;
        base_r <= base_r + AW'(fcde_pkg::SCREEN_W);
      end else begin
        cx_r <= cx_inc;
      end
    end
    if (cmd.result) begin
      inb_r <= is_read && !empty_r;
      pix_r <= (is_read && !empty_r) ? ram_rdata : '0;
    end
  end

  assign ram_addr = base_r + AW'(cx_r);

  fcde_ram #(
    .WIDTH(fcde_pkg::COL_W),
    .DEPTH(fcde_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (cmd.ram_we || cmd.ram_re),
    .we    (cmd.ram_we),
    .addr  (ram_addr),
    .wdata (colour_r),
    .rdata (ram_rdata)
  );

  assign stat.empty     = empty_r;
  assign stat.is_read   = is_read;
  assign stat.last_pass = (op_r != fcde_pkg::OP_OUTLINE) ||
                          (pass_r == PW'(fcde_pkg::OUTLINE_PASSES - 1));
  assign stat.col_last  = (cx_inc == x1_r);
  assign stat.row_last  = (cy_inc == y1_r);

  assign out_pixel_value    = pix_r;
  assign out_read_in_bounds = inb_r;

endmodule

// ===== hdl/framebuffer_clipped_draw_engine_unit.sv =====
// Clipped draw engine top: 320x240 16-bit framebuffer, one command at a time.
// Outlines are drawn in four passes (top, bottom, left, right edges); off-screen commands
// and unused op codes finish without touching the frame store.
// Throughput: one pixel written per cycle; the next command is taken the cycle after the
// result is handed off, while that result may still wait on the output.
// Reset (rst_n, synchronous): sequencer idle, no result pending; frame store not cleared.
module framebuffer_clipped_draw_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  fcde_in_if.sink     in_ch,
  fcde_out_if.source  out_ch
);

  fcde_pkg::ctrl_cmd_t cmd;
  fcde_pkg::dp_stat_t  stat;

  fcde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  fcde_dp u_dp (
    .clk                (clk),
    .cmd                (cmd),
    .stat               (stat),
    .in_op              (in_ch.op),
    .in_pos_x           (in_ch.pos_x),
    .in_pos_y           (in_ch.pos_y),
    .in_span_w          (in_ch.span_w),
    .in_span_h          (in_ch.span_h),
    .in_colour          (in_ch.colour),
    .out_pixel_value    (out_ch.pixel_value),
    .out_read_in_bounds (out_ch.read_in_bounds)
  );

endmodule
